// File: sv/rpgc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the row pair gain corrector.
// No dependencies; every other file but rpgc_checker imports this package.
package rpgc_pkg;

	localparam int PIX_W       = 8;
	localparam int DIM_W       = 13;
	localparam int CNT_W       = 12;
	localparam int RATIO_W     = 9;
	localparam int GAIN_W      = 17;
	localparam int LVL_W       = 11;  // 256 + ratio, signed
	localparam int ADJ_W       = 10;  // interpolated gain after clamping at zero
	localparam int DIVIDEND_W  = 21;
	localparam int DIVISOR_W   = 13;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 13;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [DIM_W-1:0]      MAX_WIDTH     = 13'd4096;
	localparam logic [DIM_W-1:0]      MAX_HEIGHT    = 13'd4096;
	localparam logic [DIM_W-1:0]      RESET_WIDTH   = 13'd640;
	localparam logic [DIM_W-1:0]      RESET_HEIGHT  = 13'd480;
	localparam logic [GAIN_W-1:0]     UNITY_GAIN    = 17'd256;
	localparam logic [ADJ_W-1:0]      UNITY_ADJ     = 10'd256;
	localparam logic [GAIN_W-1:0]     GAIN_ALL_ONES = 17'h1FFFF;
	localparam logic [DIVIDEND_W-1:0] RECIP_NUM     = DIVIDEND_W'(256 * 256 + 128);
	localparam logic [PIX_W-1:0]      PIX_MAX       = 8'd255;
	localparam int                    GAIN_SHIFT    = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH   = 3'd0,
		REG_HEIGHT  = 3'd1,
		REG_REVERSE = 3'd2,
		REG_TOP     = 3'd3,
		REG_BOTTOM  = 3'd4
	} cfg_reg_t;

	// Dimensions are stored already clamped to 1 .. MAX.
	typedef struct packed {
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic               reverse;
		logic [RATIO_W-1:0] top_ratio;
		logic [RATIO_W-1:0] bottom_ratio;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [CNT_W-1:0] row;
		logic             new_pair;
		logic             frame_end;
	} pix_item_t;

endpackage

// File: sv/rpgc_front.sv
`timescale 1ns / 1ps
// Front end: takes pixels, tracks column and row, tags pair starts and frame ends.
// Depends on rpgc_pkg.
module rpgc_front import rpgc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] pixel_in,
	input  logic             frame_start,
	input  logic             q_full,
	output logic             push,
	output pix_item_t        item
);

	logic [CNT_W-1:0] column_q;
	logic [CNT_W-1:0] row_q;
	logic [CNT_W-1:0] col_c;
	logic [CNT_W-1:0] row_c;
	logic             row_end;
	logic             frame_end;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		col_c     = frame_start ? '0 : column_q;
		row_c     = frame_start ? '0 : row_q;
		row_end   = ({1'b0, col_c} + 13'd1) >= cfg.width;
		frame_end = row_end && (({1'b0, row_c} + 13'd1) >= cfg.height);

		item.pixel     = pixel_in;
		item.row       = row_c;
		item.new_pair  = (col_c == '0) && !row_c[0];
		item.frame_end = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (push) begin
			if (row_end) begin
				column_q <= '0;
				row_q    <= frame_end ? '0 : row_c + 12'd1;
			end else begin
				column_q <= col_c + 12'd1;
				row_q    <= row_c;
			end
		end
	end

endmodule

// File: sv/rpgc_queue.sv
`timescale 1ns / 1ps
// Short queue between the front end and the gain back end.
// Depends on rpgc_pkg.
module rpgc_queue import rpgc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pix_item_t item,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output pix_item_t head
);

	pix_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = count_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: sv/rpgc_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by both gain divisions.
// Depends on rpgc_pkg.
module rpgc_div import rpgc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int DCNT_W = $clog2(DIVIDEND_W);
	localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(DIVIDEND_W - 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [DCNT_W-1:0]     cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W:0]    trial;
	logic                  ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
		trial  = rem_sh - {1'b0, divisor_q};
		ge     = rem_sh >= {1'b0, divisor_q};
	end

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q     <= '0;
			rem_q     <= '0;
			divisor_q <= '0;
			cnt_q     <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
		end else if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
			cnt_q     <= '0;
			busy_q    <= 1'b1;
			done_q    <= 1'b0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the low bits are enough
			rem_q <= ge ? trial[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

// File: sv/rpgc_back.sv
`timescale 1ns / 1ps
// Back end: works out the pair gain at each pair start, scales pixels, holds the output.
// Depends on rpgc_pkg and rpgc_div.
module rpgc_back import rpgc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             head_valid,
	input  pix_item_t        head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] out_pixel,
	output logic             out_last
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_Q_GO,
		ST_Q_WAIT,
		ST_CLASS,
		ST_R_GO,
		ST_R_WAIT,
		ST_APPLY
	} state_t;

	localparam int PROD_W = PIX_W + GAIN_W;

	function automatic logic [PIX_W-1:0] scale_pix(input logic [PIX_W-1:0] p,
			input logic [GAIN_W-1:0] g);
		logic [PROD_W-1:0] prod;
		prod = {{GAIN_W{1'b0}}, p} * {{PIX_W{1'b0}}, g};
		if (|prod[PROD_W-1:GAIN_SHIFT+PIX_W])
			return PIX_MAX;
		return prod[GAIN_SHIFT+PIX_W-1:GAIN_SHIFT];
	endfunction

	state_t                   state_q;
	pix_item_t                hold_q;
	logic [CNT_W-1:0]         t_q;
	logic signed [LVL_W-1:0]  diff_q;
	logic                     neg_q;
	logic [DIVIDEND_W-1:0]    mag_q;
	logic [ADJ_W-1:0]         adj_q;
	logic [GAIN_W-1:0]        gain_q;
	logic                     sel_q;
	logic                     active_q;
	logic                     out_valid_q;
	logic [PIX_W-1:0]         out_pixel_q;
	logic                     out_last_q;

	logic                     out_free;
	logic                     out_load;
	logic signed [LVL_W-1:0]  top_lvl;
	logic signed [LVL_W-1:0]  bot_lvl;
	logic signed [DIM_W:0]    t_raw;
	logic signed [DIM_W:0]    h_last;
	logic [CNT_W-1:0]         t_c;
	logic signed [24:0]       num_c;
	logic [24:0]              num_abs;
	logic signed [LVL_W:0]    q_s;
	logic signed [LVL_W:0]    adj_s;
	logic                     div_start;
	logic [DIVIDEND_W-1:0]    div_dividend;
	logic [DIVISOR_W-1:0]     div_divisor;
	logic                     div_done;
	logic [DIVIDEND_W-1:0]    div_quotient;
	logic                     hit_head;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		top_lvl = 11'sd256 + $signed({{(LVL_W-RATIO_W){cfg.top_ratio[RATIO_W-1]}},
			cfg.top_ratio});
		bot_lvl = 11'sd256 + $signed({{(LVL_W-RATIO_W){cfg.bottom_ratio[RATIO_W-1]}},
			cfg.bottom_ratio});

		// height term, clamped to 0 .. H-1
		h_last = $signed({1'b0, cfg.height}) - 14'sd1;
		if (cfg.reverse)
			t_raw = h_last - $signed({2'b00, hold_q.row});
		else
			t_raw = $signed({2'b00, hold_q.row});
		if (t_raw < 0)
			t_c = '0;
		else if (t_raw > h_last)
			t_c = h_last[CNT_W-1:0];
		else
			t_c = t_raw[CNT_W-1:0];

		num_c   = 25'(diff_q) * 25'($signed({1'b0, t_q})) + 25'(cfg.height >> 1);
		num_abs = num_c[24] ? 25'(-num_c) : 25'(num_c);

		// truncation toward zero: divide the magnitude, then restore the sign
		q_s   = neg_q ? -$signed({2'b00, div_quotient[ADJ_W-1:0]})
		              : $signed({2'b00, div_quotient[ADJ_W-1:0]});
		adj_s = $signed({top_lvl[LVL_W-1], top_lvl}) + q_s;

		div_start    = (state_q == ST_Q_GO) || (state_q == ST_R_GO);
		div_dividend = (state_q == ST_R_GO) ? RECIP_NUM : mag_q;
		div_divisor  = (state_q == ST_R_GO) ? DIVISOR_W'(adj_q) : cfg.height;

		hit_head = active_q && (head.row[0] == sel_q);
		pop      = (state_q == ST_IDLE) && head_valid && (head.new_pair || out_free);
		out_load = ((state_q == ST_IDLE) && pop && !head.new_pair)
			|| ((state_q == ST_APPLY) && out_free);
	end

	rpgc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hold_q      <= '0;
			t_q         <= '0;
			diff_q      <= '0;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			adj_q       <= '0;
			gain_q      <= UNITY_GAIN;
			sel_q       <= 1'b0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_pixel_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.new_pair) begin
							hold_q  <= head;
							state_q <= ST_PREP;
						end else begin
							out_pixel_q <= hit_head ? scale_pix(head.pixel, gain_q) : head.pixel;
							out_last_q  <= head.frame_end;
						end
					end
				end
				ST_PREP: begin
					t_q     <= t_c;
					diff_q  <= bot_lvl - top_lvl;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					neg_q   <= num_c[24];
					mag_q   <= num_abs[DIVIDEND_W-1:0];
					state_q <= ST_Q_GO;
				end
				ST_Q_GO: begin
					state_q <= ST_Q_WAIT;
				end
				ST_Q_WAIT: begin
					if (div_done) begin
						adj_q   <= adj_s[LVL_W] ? '0 : adj_s[ADJ_W-1:0];
						state_q <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					if (adj_q == UNITY_ADJ) begin
						active_q <= 1'b0;
						gain_q   <= UNITY_GAIN;
						sel_q    <= 1'b0;
						state_q  <= ST_APPLY;
					end else if (adj_q > UNITY_ADJ) begin
						active_q <= 1'b1;
						gain_q   <= GAIN_W'(adj_q);
						sel_q    <= !cfg.reverse;
						state_q  <= ST_APPLY;
					end else begin
						// darker gain turns into a reciprocal on the other row
						active_q <= 1'b1;
						sel_q    <= cfg.reverse;
						if (adj_q == '0) begin
							gain_q  <= GAIN_ALL_ONES;
							state_q <= ST_APPLY;
						end else begin
							state_q <= ST_R_GO;
						end
					end
				end
				ST_R_GO: begin
					state_q <= ST_R_WAIT;
				end
				ST_R_WAIT: begin
					if (div_done) begin
						gain_q  <= div_quotient[GAIN_W-1:0];
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (out_free) begin
						out_pixel_q <= (active_q && (hold_q.row[0] == sel_q))
							? scale_pix(hold_q.pixel, gain_q) : hold_q.pixel;
						out_last_q  <= hold_q.frame_end;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign out_last  = out_last_q;

endmodule

// File: sv/row_pair_gain_corrector_unit.sv
`timescale 1ns / 1ps
// Row pair gain corrector. Gray pixels stream in raster order, one per cycle while the
// queue has room and the output is not stalled, and each comes out once, in order, on
// the master side. The first pixel of every even row holds the back end while the pair
// gain is worked out through a 21-step pass of a shared bit-serial divider, plus a
// second pass when a reciprocal gain has to be divided out. A two-entry queue lets two
// more pixels in while the divider runs. Configuration writes are always taken; make
// them while no pixel is in flight, and gain settings act from the next row pair on.
// Depends on rpgc_pkg, rpgc_front, rpgc_queue, rpgc_div and rpgc_back.
module row_pair_gain_corrector_unit import rpgc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] pixel_in
	input  logic                  s_tuser,   // [0] frame_start
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [7:0] pixel_out
	output logic                  m_tlast,   // frame_end
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		if (v == '0)
			return DIM_W'(1);
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	cfg_t      cfg_q;
	logic      q_full;
	logic      push;
	pix_item_t item;
	logic      pop;
	logic      head_valid;
	pix_item_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width        <= RESET_WIDTH;
			cfg_q.height       <= RESET_HEIGHT;
			cfg_q.reverse      <= 1'b0;
			cfg_q.top_ratio    <= '0;
			cfg_q.bottom_ratio <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:   cfg_q.width        <= eff_dim(cfg_data, MAX_WIDTH);
				REG_HEIGHT:  cfg_q.height       <= eff_dim(cfg_data, MAX_HEIGHT);
				REG_REVERSE: cfg_q.reverse      <= cfg_data[0];
				REG_TOP:     cfg_q.top_ratio    <= cfg_data[RATIO_W-1:0];
				REG_BOTTOM:  cfg_q.bottom_ratio <= cfg_data[RATIO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rpgc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.pixel_in    (s_tdata),
		.frame_start (s_tuser),
		.q_full      (q_full),
		.push        (push),
		.item        (item)
	);

	rpgc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	rpgc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_pixel  (m_tdata),
		.out_last   (m_tlast)
	);

endmodule

// File: sv/rpgc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the row pair gain corrector, bound to the top level.
// Depends on row_pair_gain_corrector_unit.
module rpgc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       cfg_ready
);

	// pixels taken in and not yet handed out: queue, held pair start, output register
	logic [2:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else
			inflight_q <= inflight_q + {2'b00, s_tvalid && s_tready}
				- {2'b00, m_tvalid && m_tready};
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transfer dropped or changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 3'd0)
		else $error("output shown with no pixel in flight");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd4)
		else $error("more pixels in flight than the block can store");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> inflight_q >= 3'd2)
		else $error("input stalled while the queue has room");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port stalled");

endmodule

bind row_pair_gain_corrector_unit rpgc_checker u_rpgc_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for row_pair_gain_corrector_unit: pixel streams under random
// backpressure, checked against a per-pair gain predictor kept in a small class.
// Depends on rpgc_pkg and the unit's RTL.
module tb;
	import rpgc_pkg::*;

	localparam int ITEM_TARGET  = 1000;
	localparam int QUIET_LIMIT  = 4000;  // cycles with no transfer on any channel
	localparam int DRAIN_CYCLES = 80;    // covers the pair gain divides
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_DIM      = 4096;
	localparam int MAX_REPORTS  = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // decodes to no register

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             frame_end;
	} out_pixel_t;

	typedef enum int {READY_ALWAYS, READY_COIN, READY_ONE_IN_FOUR, READY_MOSTLY} stall_mode_t;

	class pair_gain_checker;
		logic [DIM_W-1:0]   width_reg;
		logic [DIM_W-1:0]   height_reg;
		logic               reverse_reg;
		logic [RATIO_W-1:0] top_reg;
		logic [RATIO_W-1:0] bottom_reg;
		int                 col;
		int                 row;
		int                 gain;
		logic               row_sel;
		logic               active;
		out_pixel_t         expected_pixels[$];
		int                 failures;

		function void reset_state();
			width_reg = RESET_WIDTH;
			height_reg = RESET_HEIGHT;
			reverse_reg = 1'b0;
			top_reg = '0;
			bottom_reg = '0;
			col = 0;
			row = 0;
			gain = int'(UNITY_GAIN);
			row_sel = 1'b0;
			active = 1'b0;
			failures = 0;
			expected_pixels.delete();
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_WIDTH:   width_reg = data[DIM_W-1:0];
				REG_HEIGHT:  height_reg = data[DIM_W-1:0];
				REG_REVERSE: reverse_reg = data[0];
				REG_TOP:     top_reg = data[RATIO_W-1:0];
				REG_BOTTOM:  bottom_reg = data[RATIO_W-1:0];
				default: ;
			endcase
		endfunction

		function int clamp_dim(logic [DIM_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > MAX_DIM)
				return MAX_DIM;
			return int'(v);
		endfunction

		function void work_out_pair_gain(int h);
			int top_lvl;
			int bot_lvl;
			int t;
			int adj;
			top_lvl = 256 + int'($signed(top_reg));
			bot_lvl = 256 + int'($signed(bottom_reg));
			t = reverse_reg ? h - 1 - row : row;
			if (t < 0)
				t = 0;
			if (t > h - 1)
				t = h - 1;
			// signed division truncates toward zero
			adj = top_lvl + ((bot_lvl - top_lvl) * t + h / 2) / h;
			if (adj < 0)
				adj = 0;
			if (adj == int'(UNITY_ADJ)) begin
				active = 1'b0;
				gain = int'(UNITY_GAIN);
				row_sel = 1'b0;
			end else if (adj > int'(UNITY_ADJ)) begin
				active = 1'b1;
				gain = adj;
				row_sel = !reverse_reg;
			end else begin
				active = 1'b1;
				gain = (adj == 0) ? int'(GAIN_ALL_ONES) : int'(RECIP_NUM) / adj;
				row_sel = reverse_reg;
			end
		endfunction

		function bit at_frame_start();
			return col == 0 && row == 0;
		endfunction

		function void take_pixel(logic [PIX_W-1:0] p, logic fs);
			int         w;
			int         h;
			int         v;
			logic       row_end;
			out_pixel_t e;
			w = clamp_dim(width_reg);
			h = clamp_dim(height_reg);
			if (fs) begin
				col = 0;
				row = 0;
			end
			if (col == 0 && row[0] == 1'b0)
				work_out_pair_gain(h);
			e.pixel = p;
			if (active && row[0] == row_sel) begin
				v = (int'(p) * gain) >> GAIN_SHIFT;
				e.pixel = (v > int'(PIX_MAX)) ? PIX_MAX : v[PIX_W-1:0];
			end
			row_end = (col + 1 >= w);
			e.frame_end = row_end && (row + 1 >= h);
			if (row_end) begin
				col = 0;
				row = e.frame_end ? 0 : ((row + 1) & 12'hFFF);
			end else begin
				col = (col + 1) & 12'hFFF;
			end
			expected_pixels.push_back(e);
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= MAX_REPORTS)
				$display("%0t: %s", $time, msg);
		endfunction

		function void check_pixel(logic [PIX_W-1:0] p, logic last);
			out_pixel_t e;
			if (expected_pixels.size() == 0) begin
				flag($sformatf("pixel %0d last %0b came out with nothing expected", p, last));
				return;
			end
			e = expected_pixels.pop_front();
			if (p !== e.pixel || last !== e.frame_end)
				flag($sformatf("pixel mismatch: expected %0d last %0b, got %0d last %0b",
					e.pixel, e.frame_end, p, last));
		endfunction

		function void close_out();
			if (expected_pixels.size() != 0)
				flag($sformatf("%0d expected pixels never came out", expected_pixels.size()));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pair_gain_checker pixel_check = new;
	logic             hold_req = 1'b0;
	int               burst_left = 0;

	always #5 clk = ~clk;

	row_pair_gain_corrector_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		pixel_check.set_register(idx, data);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
			input logic [CFG_DATA_W-1:0] rev, input logic [CFG_DATA_W-1:0] top,
			input logic [CFG_DATA_W-1:0] bot, input bit poke_unused);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_REVERSE, rev);
		write_reg(REG_TOP, top);
		write_reg(REG_BOTTOM, bot);
		if (poke_unused)
			write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 8191)));
		cfg_valid <= 1'b0;
	endtask

	// Sender works in bursts; before most bursts tvalid drops for a random gap.
	task automatic send_pixel(input logic [7:0] p, input logic fs);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= p;
		s_tuser <= fs;
		do @(posedge clk); while (!s_tready);
		pixel_check.take_pixel(p, fs);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pixel_check.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_ratio();
		logic [3:0]         junk;
		logic [RATIO_W-1:0] r;
		junk = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 11))
			0:       r = 9'd255;
			1:       r = 9'h101;  // -255
			2:       r = 9'h100;  // -256, can drive the gain to zero
			3:       r = 9'd0;
			4:       r = 9'h1FF;
			default: r = 9'($urandom_range(0, 511));
		endcase
		return {junk, r};
	endfunction

	// Receiver: ready pattern switches mode every so often; a hold request stalls it hard.
	initial begin
		stall_mode_t      mode = READY_ALWAYS;
		int               mode_left = 0;
		int               hold_left = 0;
		int               tick = 0;
		logic             hit;
		logic [PIX_W-1:0] got_pixel;
		logic             got_last;
		forever begin
			@(posedge clk);
			hit = m_tvalid && m_tready;
			got_pixel = m_tdata;
			got_last = m_tlast;
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (mode_left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					READY_ALWAYS:      m_tready <= 1'b1;
					READY_COIN:        m_tready <= 1'($urandom_range(0, 1));
					READY_ONE_IN_FOUR: m_tready <= (tick % 4 == 0);
					default:           m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
			// check at the falling edge so the input side has noted its transfer
			if (hit) begin
				@(negedge clk);
				pixel_check.check_pixel(got_pixel, got_last);
			end
		end
	end

	initial begin
		int quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("row_pair_gain_corrector_unit regression: fail");
		$finish;
	end

	initial begin
		logic [7:0]            pair_frame[8] = '{8'd0, 8'd255, 8'd128, 8'd255,
			8'd255, 8'd0, 8'd1, 8'd254};
		logic [7:0]            wide_row[4] = '{8'd255, 8'd0, 8'd77, 8'd200};
		int                    random_sent = 0;
		int                    phase = 0;
		int                    n;
		int                    r;
		logic [CFG_DATA_W-1:0] w;
		logic [CFG_DATA_W-1:0] h;
		logic                  fs;

		pixel_check.reset_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: unity gain everywhere
		send_pixel(8'd200, 1'b1);
		send_pixel(8'd13, 1'b0);
		wait_idle();

		// steep ramp: strong brightening on the top pair, near unity on the bottom pair
		configure(13'd2, 13'd4, 13'd0, 13'd255, 13'h101, 1'b0);
		foreach (pair_frame[i])
			send_pixel(pair_frame[i], i == 0);
		wait_idle();

		// zero dimensions count as one; -256 ratios give zero gain
		configure(13'd0, 13'd0, 13'd0, 13'h100, 13'h100, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd255, 1'b0);
		wait_idle();

		// oversize dimensions clamp to the maximum; reversed interpolation
		configure(13'h1FFF, 13'h1FFF, 13'd1, 13'h101, 13'd255, 1'b0);
		foreach (wide_row[i])
			send_pixel(wide_row[i], i == 0);
		wait_idle();

		// shrink mid-row so the row ends at once; stray frame start midway
		configure(13'd3, 13'd2, 13'd1, 13'h180, 13'd100, 1'b1);
		for (int i = 0; i < 6; i++)
			send_pixel(8'($urandom_range(0, 255)), i == 3);

		while (random_sent < ITEM_TARGET) begin
			wait_idle();
			r = $urandom_range(0, 19);
			if (r < 16)
				w = CFG_DATA_W'($urandom_range(1, 12));
			else if (r == 16)
				w = CFG_DATA_W'($urandom_range(13, 64));
			else if (r == 17)
				w = '0;
			else if (r == 18)
				w = CFG_DATA_W'($urandom_range(4097, 8191));
			else
				w = CFG_DATA_W'(MAX_DIM);
			r = $urandom_range(0, 19);
			if (r < 14)
				h = CFG_DATA_W'($urandom_range(1, 10));
			else if (r < 17)
				h = CFG_DATA_W'($urandom_range(11, 40));
			else if (r == 17)
				h = '0;
			else
				h = CFG_DATA_W'($urandom_range(4000, 8191));
			configure(w, h, CFG_DATA_W'($urandom_range(0, 8191)), pick_ratio(), pick_ratio(),
				$urandom_range(0, 7) == 0);
			n = $urandom_range(20, 80);
			if (phase == 4) begin
				// long receiver stall while pixels keep coming: the input must back up
				hold_req = 1'b1;
				n = 120;
			end
			for (int i = 0; i < n; i++) begin
				// mostly well-formed frames: start flag at frame boundaries, rare strays
				if (pixel_check.at_frame_start())
					fs = ($urandom_range(0, 9) < 8);
				else
					fs = ($urandom_range(0, 49) == 0);
				send_pixel(8'($urandom_range(0, 255)), fs);
			end
			random_sent += n;
			phase++;
		end

		wait_idle();
		pixel_check.close_out();
		if (pixel_check.failures == 0)
			$display("row_pair_gain_corrector_unit regression: pass");
		else
			$display("row_pair_gain_corrector_unit regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
sv/rpgc_pkg.sv
sv/rpgc_front.sv
sv/rpgc_queue.sv
sv/rpgc_div.sv
sv/rpgc_back.sv
sv/row_pair_gain_corrector_unit.sv
sv/rpgc_checker.sv
bench/tb.sv
